### src/wdlm_pkg.sv
// ----------------------------------------------------------------------------
// wdlm_pkg
// Shared codes, default sizes and the decision record of the wait-die lock
// manager.
// ----------------------------------------------------------------------------
`default_nettype none

package wdlm_pkg;

  // default table sizes
  localparam int NUM_LOCKS_DEF    = 256;
  localparam int NUM_CONTEXTS_DEF = 16;
  localparam int TICKET_BITS_DEF  = 32;

  // request opcodes
  localparam logic [1:0] OP_LOCK   = 2'd0;
  localparam logic [1:0] OP_TRY    = 2'd1;
  localparam logic [1:0] OP_UNLOCK = 2'd2;

  // response status codes
  localparam logic [1:0] ST_GRANTED = 2'd0;
  localparam logic [1:0] ST_ALREADY = 2'd1;
  localparam logic [1:0] ST_BACKOFF = 2'd2;
  localparam logic [1:0] ST_BUSY    = 2'd3;

  // what the decision logic asks the write-back path to do
  typedef struct packed {
    logic [1:0] status;
    logic       wake;
    logic       lock_wr;   // write the lock entry back
    logic       lock_held; // new held bit
    logic       lock_own;  // new owner is the requesting context
    logic       ctx_wr;    // write the context entry back
    logic       ctx_set;   // mark contending on this lock, else clear
  } act_t;

endpackage

`default_nettype wire

### src/wdlm_ram.sv
// ----------------------------------------------------------------------------
// wdlm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module wdlm_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered: with re set, data appears in the cycle after the address
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/wdlm_decide.sv
// ----------------------------------------------------------------------------
// wdlm_decide
// Wait-die decision: from the request and the entries read from the lock and
// context tables, picks the status and the write-back actions.
// ----------------------------------------------------------------------------
`default_nettype none

module wdlm_decide #(
  parameter int LIW = 8,
  parameter int CXW = 4,
  parameter int TKW = 32
) (
  input  wire logic [1:0]         opcode,
  input  wire logic               lock_ok,
  input  wire logic               ctx_ok,
  input  wire logic [LIW-1:0]     lock_addr,
  input  wire logic [CXW-1:0]     ctx,
  input  wire logic [TKW-1:0]     tk,
  input  wire logic               ent_held,
  input  wire logic               ent_own_vld,
  input  wire logic [CXW-1:0]     ent_owner,
  input  wire logic [TKW-1:0]     ent_tk,
  input  wire logic               cnt_vld,
  input  wire logic [LIW-1:0]     cnt_lock,
  output wdlm_pkg::act_t          act
);

  logic on_this_lock;

  assign on_this_lock = cnt_vld && (cnt_lock == lock_addr);

  always_comb begin
    act        = '0;
    act.status = wdlm_pkg::ST_BUSY;
    if (lock_ok) begin
      case (opcode)
        wdlm_pkg::OP_LOCK: begin
          if (ctx_ok) begin
            if (!ent_held) begin
              // free: grant and drop a contention mark on this lock
              act.status    = wdlm_pkg::ST_GRANTED;
              act.lock_wr   = 1'b1;
              act.lock_held = 1'b1;
              act.lock_own  = 1'b1;
              act.ctx_wr    = on_this_lock;
              act.ctx_set   = 1'b0;
            end else if (ent_own_vld && (ent_owner == ctx)) begin
              act.status = wdlm_pkg::ST_ALREADY;
            end else if (!on_this_lock && ent_own_vld && (ent_tk < tk)) begin
              // younger requester against an older owner dies once
              act.status  = wdlm_pkg::ST_BACKOFF;
              act.ctx_wr  = 1'b1;
              act.ctx_set = 1'b1;
            end
          end
        end
        wdlm_pkg::OP_TRY: begin
          if (!ent_held) begin
            act.status    = wdlm_pkg::ST_GRANTED;
            act.lock_wr   = 1'b1;
            act.lock_held = 1'b1;
          end
        end
        wdlm_pkg::OP_UNLOCK: begin
          // unconditional release, owner not checked
          act.status  = wdlm_pkg::ST_GRANTED;
          act.wake    = 1'b1;
          act.lock_wr = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### src/wait_die_lock_manager.sv
// ----------------------------------------------------------------------------
// wait_die_lock_manager
// Wait-die mutex lock table with per-context contention marks.
// ----------------------------------------------------------------------------
// In the accept cycle the lock entry and the context entry of an item are
// read from their synchronous RAMs. In the decision state that follows, the
// wait-die decision is made, and once the response register is free both
// entries are written back and the response register is loaded. The next
// item is accepted only after that write-back, so a following item on the
// same lock or context always reads updated entries. An item may be accepted
// while a response still waits; it then stalls in the decision state until
// the response register frees. After reset both tables are cleared by a pass
// over every entry of the larger table, during which req_ready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module wait_die_lock_manager #(
  parameter int NUM_LOCKS    = wdlm_pkg::NUM_LOCKS_DEF,
  parameter int NUM_CONTEXTS = wdlm_pkg::NUM_CONTEXTS_DEF,
  parameter int TICKET_BITS  = wdlm_pkg::TICKET_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  lock_index,
  input  wire logic [3:0]  ctx_id,
  input  wire logic [31:0] ticket,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output logic [1:0]       status,
  output logic             wake_waiters
);

  localparam int LIW     = $clog2(NUM_LOCKS);
  localparam int CXW     = $clog2(NUM_CONTEXTS);
  localparam int TKW     = (TICKET_BITS < 32) ? TICKET_BITS : 32;
  localparam int LEW     = 2 + CXW + TKW;
  localparam int CEW     = 1 + LIW;
  localparam int CLR_LEN = (NUM_LOCKS > NUM_CONTEXTS) ? NUM_LOCKS : NUM_CONTEXTS;
  localparam int CLRW    = $clog2(CLR_LEN);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]      state;
  logic [1:0]      state_next;
  logic [CLRW-1:0] clr_cnt;
  logic            clr_last;

  // captured request
  logic [1:0]      rq_op;
  logic [LIW-1:0]  rq_lock;
  logic [CXW-1:0]  rq_ctx;
  logic [TKW-1:0]  rq_tk;
  logic            rq_lock_ok;
  logic            rq_ctx_ok;

  logic            req_acc;
  logic            exec_done;
  logic            in_clear;

  logic            lk_we;
  logic [LIW-1:0]  lk_waddr;
  logic [LEW-1:0]  lk_wdata;
  logic [LEW-1:0]  lk_rdata;
  logic            cx_we;
  logic [CXW-1:0]  cx_waddr;
  logic [CEW-1:0]  cx_wdata;
  logic [CEW-1:0]  cx_rdata;

  wdlm_pkg::act_t  act;

  assign in_clear  = (state == S_CLEAR);
  assign req_ready = (state == S_IDLE);
  assign req_acc   = req_valid && req_ready;
  assign exec_done = (state == S_EXEC) && (!rsp_valid || rsp_ready);
  assign clr_last  = (clr_cnt == CLRW'(CLR_LEN - 1));

  // control state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_last) state_next = S_IDLE;
      S_IDLE:  if (req_acc) state_next = S_EXEC;
      S_EXEC:  if (exec_done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (in_clear) begin
        clr_cnt <= clr_cnt + CLRW'(1);
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (req_acc) begin
      rq_op      <= opcode;
      rq_lock    <= LIW'(lock_index);
      rq_ctx     <= CXW'(ctx_id);
      rq_tk      <= TKW'(ticket);
      rq_lock_ok <= (32'(lock_index) < NUM_LOCKS);
      rq_ctx_ok  <= (32'(ctx_id) < NUM_CONTEXTS);
    end
  end

  // lock table write port: clearing pass or write-back
  always_comb begin
    if (in_clear) begin
      lk_we    = (32'(clr_cnt) < NUM_LOCKS);
      lk_waddr = clr_cnt[LIW-1:0];
      lk_wdata = '0;
    end else begin
      lk_we    = exec_done && act.lock_wr;
      lk_waddr = rq_lock;
      lk_wdata = {act.lock_held, act.lock_own,
                  act.lock_own ? rq_ctx : {CXW{1'b0}},
                  act.lock_own ? rq_tk : {TKW{1'b0}}};
    end
  end

  // context table write port
  always_comb begin
    if (in_clear) begin
      cx_we    = (32'(clr_cnt) < NUM_CONTEXTS);
      cx_waddr = clr_cnt[CXW-1:0];
      cx_wdata = '0;
    end else begin
      cx_we    = exec_done && act.ctx_wr;
      cx_waddr = rq_ctx;
      cx_wdata = {act.ctx_set, rq_lock};
    end
  end

  wdlm_ram #(
    .DEPTH (NUM_LOCKS),
    .WIDTH (LEW),
    .AW    (LIW)
  ) u_lock_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (req_acc),
    .raddr (LIW'(lock_index)),
    .rdata (lk_rdata)
  );

  wdlm_ram #(
    .DEPTH (NUM_CONTEXTS),
    .WIDTH (CEW),
    .AW    (CXW)
  ) u_ctx_ram (
    .clk   (clk),
    .we    (cx_we),
    .waddr (cx_waddr),
    .wdata (cx_wdata),
    .re    (req_acc),
    .raddr (CXW'(ctx_id)),
    .rdata (cx_rdata)
  );

  wdlm_decide #(
    .LIW (LIW),
    .CXW (CXW),
    .TKW (TKW)
  ) u_decide (
    .opcode      (rq_op),
    .lock_ok     (rq_lock_ok),
    .ctx_ok      (rq_ctx_ok),
    .lock_addr   (rq_lock),
    .ctx         (rq_ctx),
    .tk          (rq_tk),
    .ent_held    (lk_rdata[LEW-1]),
    .ent_own_vld (lk_rdata[LEW-2]),
    .ent_owner   (lk_rdata[LEW-3 -: CXW]),
    .ent_tk      (lk_rdata[TKW-1:0]),
    .cnt_vld     (cx_rdata[LIW]),
    .cnt_lock    (cx_rdata[LIW-1:0]),
    .act         (act)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec_done) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      status       <= act.status;
      wake_waiters <= act.wake;
    end
  end

endmodule

`default_nettype wire

### src/wdlm_checker.sv
// ----------------------------------------------------------------------------
// wdlm_port_checker
// Port-level checks of the lock manager, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module wdlm_port_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [1:0]  status,
  input wire logic        wake_waiters
);

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(wake_waiters))
    else $error("stalled response changed");

  // a wake is only sent with a granted unlock
  a_wake_granted: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && wake_waiters |-> status == wdlm_pkg::ST_GRANTED)
    else $error("wake with non-granted status");

  // one item in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready right after accept");

  // with the response side empty, the response is not valid in the decision state and shows once registered
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !rsp_valid |=> !rsp_valid ##1 rsp_valid)
    else $error("response latency broken");

endmodule

bind wait_die_lock_manager wdlm_port_checker u_wdlm_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req_valid),
  .req_ready    (req_ready),
  .rsp_valid    (rsp_valid),
  .rsp_ready    (rsp_ready),
  .status       (status),
  .wake_waiters (wake_waiters)
);

`default_nettype wire
